[sv/mede_pkg.sv]
// ----------------------------------------------------------------------------
// mede_pkg
// shared types and constants of the multi-encoder detent reporter
// ----------------------------------------------------------------------------
package mede_pkg;

	localparam int CHANNELS = 8;
	localparam int PIN_W    = 16;
	localparam int FLAG_W   = 8;
	localparam int HOLD_W   = 16;
	localparam int THR_W    = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [HOLD_W-1:0] HOLD_TICKS_RST     = 16'h0300;
	localparam logic [THR_W-1:0]  FAST_THRESHOLD_RST = 4'd3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESHOLD = 1'b1;

	// item command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [PIN_W-1:0] encoder_pins;
	} in_word_t;

	typedef struct packed {
		logic [PIN_W-1:0]  encoder_report;
		logic [FLAG_W-1:0] fast_flags;
		logic              report_fresh;
	} out_word_t;

	typedef logic [CHANNELS-1:0][1:0] phase_vec_t;

	// result of one pass through the detent chain
	typedef struct packed {
		phase_vec_t        phase;
		logic [PIN_W-1:0]  dir_bits;
		logic [FLAG_W-1:0] fast_bits;
		logic [THR_W-1:0]  count;
		logic              changed;
	} chain_res_t;

	// events seen by the hold timer
	typedef struct packed {
		logic tick;
		logic sample;
		logic fresh;
	} tmr_ctrl_t;

endpackage

[sv/mede_detent_chain.sv]
// ----------------------------------------------------------------------------
// mede_detent_chain
// per-channel direction decode through the shared detent counter
// ----------------------------------------------------------------------------
module mede_detent_chain (
	input  logic [mede_pkg::PIN_W-1:0] pins,
	input  mede_pkg::phase_vec_t       prev_phase,
	input  logic [mede_pkg::THR_W-1:0] detent_count,
	input  logic [mede_pkg::THR_W-1:0] fast_threshold,
	output mede_pkg::chain_res_t       res
);
	import mede_pkg::*;

	// channels in order, the counter ripples from one to the next
	always_comb begin
		logic [THR_W-1:0] cnt;
		logic [1:0]       now;
		logic [1:0]       old;
		logic             ccw;
		cnt = detent_count;
		res = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			now = pins[2*ch +: 2];
			old = prev_phase[ch];
			ccw = now[1] ^ old[0];
			res.phase[ch] = now;
			if (now != old) begin
				res.changed = 1'b1;
				if (cnt < fast_threshold) begin
					res.dir_bits[2*ch +: 2] = ccw ? 2'b01 : 2'b10;
					cnt = cnt + THR_W'(1);
				end else begin
					res.fast_bits[ch] = 1'b1;
					cnt = '0;
				end
			end
		end
		res.count = cnt;
	end

endmodule

[sv/mede_hold_timer.sv]
// ----------------------------------------------------------------------------
// mede_hold_timer
// tick counter that flags expiry of the held report
// ----------------------------------------------------------------------------
module mede_hold_timer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mede_pkg::tmr_ctrl_t         ctrl,
	input  logic [mede_pkg::HOLD_W-1:0] hold_ticks,
	output logic                        expired
);
	import mede_pkg::*;

	logic [HOLD_W-1:0] count_q;
	logic              expired_q;
	logic [HOLD_W-1:0] count_inc;

	assign count_inc = count_q + HOLD_W'(1);
	assign expired   = expired_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			expired_q <= 1'b0;
		end else if (ctrl.tick) begin
			if (count_inc >= hold_ticks) begin
				count_q   <= '0;
				expired_q <= 1'b1;
			end else begin
				count_q <= count_inc;
			end
		end else if (ctrl.sample) begin
			// a sample always consumes the expiry, a relatch also restarts the count
			expired_q <= 1'b0;
			if (ctrl.fresh) begin
				count_q <= '0;
			end
		end
	end

endmodule

[sv/multi_encoder_detent_reporter.sv]
// ----------------------------------------------------------------------------
// multi_encoder_detent_reporter
// eight-channel quadrature encoder decoder with detent and hold logic
// ----------------------------------------------------------------------------
// Takes one word per clock while item_stall is low: a pin sample (cmd 0)
// carrying the two phase lines of eight encoders, or a timer tick (cmd 1).
// Every sample gives one result word, through the input register and then
// the result register; ticks give none. The sustained rate is one word per
// cycle while results drain; the detent chain between the two registers is
// combinational. The input register keeps taking words while a result
// waits; only a sample sitting in the input register behind a stalled
// result holds item_stall high. Configuration writes are taken at any time
// with cfg_ready always high and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module multi_encoder_detent_reporter (
	input  logic                           clk,
	input  logic                           arst_n,
	// item channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  mede_pkg::in_word_t             item,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output mede_pkg::out_word_t            result,
	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mede_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mede_pkg::HOLD_W-1:0]    cfg_data
);
	import mede_pkg::*;

	// configuration registers
	logic [HOLD_W-1:0] hold_ticks_q;
	logic [THR_W-1:0]  fast_threshold_q;

	// input stage
	logic     valid_s1;
	in_word_t item_s1;

	// block state
	phase_vec_t       prev_phase_q;
	logic [THR_W-1:0] detent_q;
	logic             pending_q;
	logic [PIN_W-1:0] held_q;

	// chain and timer
	chain_res_t chain;
	tmr_ctrl_t  tmr_ctrl;
	logic       expired;

	// handshake
	logic out_free;
	logic adv_s1;
	logic adv_sample;
	logic fresh;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q     <= HOLD_TICKS_RST;
			fast_threshold_q <= FAST_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HOLD_TICKS:     hold_ticks_q     <= cfg_data;
				CFG_FAST_THRESHOLD: fast_threshold_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// a tick never needs the result slot, a sample needs it free or draining
	assign out_free   = !result_valid || !result_stall;
	assign adv_s1     = valid_s1 && ((item_s1.cmd == CMD_TICK) || out_free);
	assign adv_sample = adv_s1 && (item_s1.cmd == CMD_SAMPLE);
	assign item_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	mede_detent_chain u_chain (
		.pins           (item_s1.encoder_pins),
		.prev_phase     (prev_phase_q),
		.detent_count   (detent_q),
		.fast_threshold (fast_threshold_q),
		.res            (chain)
	);

	// relatch on any phase change, or on the very first sample after reset
	assign fresh = pending_q || chain.changed;

	assign tmr_ctrl.tick   = adv_s1 && (item_s1.cmd == CMD_TICK);
	assign tmr_ctrl.sample = adv_sample;
	assign tmr_ctrl.fresh  = fresh;

	mede_hold_timer u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (tmr_ctrl),
		.hold_ticks (hold_ticks_q),
		.expired    (expired)
	);

	// state update on a sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_phase_q <= '0;
			detent_q     <= '0;
			pending_q    <= 1'b1;
			held_q       <= '0;
		end else if (adv_sample) begin
			prev_phase_q <= chain.phase;
			pending_q    <= 1'b0;
			if (fresh) begin
				held_q   <= chain.dir_bits;
				detent_q <= chain.count;
			end else if (expired) begin
				// hold time ran out with no new step: drop report and count
				held_q   <= '0;
				detent_q <= '0;
			end else begin
				detent_q <= chain.count;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv_sample) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_sample) begin
			result.encoder_report <= fresh ? chain.dir_bits : (expired ? '0 : held_q);
			result.fast_flags     <= chain.fast_bits;
			result.report_fresh   <= fresh;
		end
	end

	// a channel never shows a direction and a fast flag in the same word
	logic dir_fast_overlap;
	always_comb begin
		dir_fast_overlap = 1'b0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (result.fast_flags[ch] && (result.encoder_report[2*ch +: 2] != 2'b00)) begin
				dir_fast_overlap = 1'b1;
			end
		end
	end

	a_fresh_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.report_fresh |-> !dir_fast_overlap)
		else $error("direction and fast bit set for one channel");

	a_sample_clears_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		adv_sample |=> !expired)
		else $error("hold expiry survived a sample");

	a_pending_once: assert property (@(posedge clk) disable iff (!arst_n)
		adv_sample |=> !pending_q)
		else $error("report pending after a sample");

	a_sample_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_sample |=> result_valid)
		else $error("sample left the result register empty");

endmodule
